>>> rtl/stbs_pkg.sv
// Shared constants and codes for the sorted table binary search block.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 256;

  localparam int unsigned COUNT_W = 9;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned KEY_W   = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

>>> rtl/stbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module stbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block with its sequencer.
// A search with k probes (k at most log2(TableDepth)+1) makes one probe per cycle through the
// single compare unit and the registered read port of the key RAM, then waits until its result
// is loaded into the output register before the next word is taken. An empty table makes no probe.
// Reset clears the entry count, the sequencer and the output valid; the key RAM is not cleared.
module sorted_table_binary_search #(
  parameter int unsigned TableDepth = stbs_pkg::TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stbs_pkg::COUNT_W-1:0] cfg_data_i,   // entry_count

  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [39:0]                 s_tdata_i,    // slot [7:0], key [39:8]
  input  logic                        s_tuser_i,    // opcode

  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [7:0]                  m_tdata_o,    // match_slot [7:0]
  output logic                        m_tuser_o     // found
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  function automatic logic [AddrW-1:0] wrap_slot(input logic [stbs_pkg::SLOT_W-1:0] s);
    logic [24:0] r;
    r = 25'(s);
    for (int i = 7; i >= 0; i--) begin
      if (r >= (25'(TableDepth) << i)) begin
        r = r - (25'(TableDepth) << i);
      end
    end
    return AddrW'(r);
  endfunction

  function automatic logic [AddrW-1:0] mid_of(input logic [CntW-1:0] lo,
                                               input logic [CntW-1:0] hx);
    logic [CntW:0] sum;
    sum = {1'b0, lo} + {1'b0, hx} - (CntW + 1)'(1);
    return AddrW'(sum >> 1);
  endfunction

  logic [1:0]                    state_q, state_d;
  logic [stbs_pkg::COUNT_W-1:0]  count_q;
  logic [CntW-1:0]               low_q, low_d;
  logic [CntW-1:0]               hix_q, hix_d;
  logic [AddrW-1:0]              mid_q, mid_d;
  logic [stbs_pkg::KEY_W-1:0]    key_q, key_d;
  logic                          res_found_q, res_found_d;
  logic [stbs_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q;
  logic [stbs_pkg::SLOT_W-1:0]   out_slot_q;

  logic [stbs_pkg::SLOT_W-1:0]   in_slot;
  logic [stbs_pkg::KEY_W-1:0]    in_key;
  logic                          in_accept;
  logic [31:0]                   count_ext;
  logic [CntW-1:0]               count_c;
  logic                          ram_we;
  logic                          ram_re;
  logic [AddrW-1:0]              ram_raddr;
  logic [stbs_pkg::KEY_W-1:0]    ram_rdata;
  logic [CntW-1:0]               next_low;
  logic [CntW-1:0]               next_hix;
  logic                          out_load;

  assign in_slot   = s_tdata_i[7:0];
  assign in_key    = s_tdata_i[39:8];
  assign s_tready_o = (state_q == ST_IDLE);
  assign in_accept = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;

  assign count_ext = (32'(count_q) > 32'(TableDepth)) ? 32'(TableDepth) : 32'(count_q);
  assign count_c   = CntW'(count_ext);

  assign ram_we = in_accept && (s_tuser_i == stbs_pkg::OP_WRITE);

  stbs_ram #(
    .Width (stbs_pkg::KEY_W),
    .Depth (TableDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wrap_slot(in_slot)),
    .wdata_i (in_key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if ($signed(ram_rdata) > $signed(key_q)) begin
      next_low = low_q;
      next_hix = CntW'(32'(mid_q));
    end else begin
      next_low = CntW'(32'(mid_q) + 32'd1);
      next_hix = hix_q;
    end
  end

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_tready_i);

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    hix_d       = hix_q;
    mid_d       = mid_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    ram_re      = 1'b0;
    ram_raddr   = mid_of(CntW'(0), count_c);
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (s_tuser_i == stbs_pkg::OP_SEARCH)) begin
          key_d = in_key;
          low_d = '0;
          hix_d = count_c;
          if (count_c != '0) begin
            ram_re  = 1'b1;
            mid_d   = ram_raddr;
            state_d = ST_CMP;
          end else begin
            res_found_d = 1'b0;
            res_slot_d  = '0;
            state_d     = ST_FINISH;
          end
        end
      end
      ST_CMP: begin
        if (ram_rdata == key_q) begin
          res_found_d = 1'b1;
          res_slot_d  = stbs_pkg::SLOT_W'(32'(mid_q));
          state_d     = ST_FINISH;
        end else begin
          low_d     = next_low;
          hix_d     = next_hix;
          ram_raddr = mid_of(next_low, next_hix);
          if (next_low < next_hix) begin
            ram_re = 1'b1;
            mid_d  = ram_raddr;
          end else begin
            res_found_d = 1'b0;
            res_slot_d  = '0;
            state_d     = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    hix_q       <= hix_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_slot_q  <= res_slot_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_slot_q;
  assign m_tuser_o  = out_found_q;

endmodule
